FILE: hw/rtl/fcs_pkg.sv
// fast cosine/sine unit: shared constants, function codes, stage types
// and fixed-point rounding helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

   // default fraction widths of the angle and of the results
   localparam int ANGLE_FRAC_BITS_DEF  = 28;
   localparam int RESULT_FRAC_BITS_DEF = 30;

   // internal fraction width
   localparam int WF = 30;

   // function codes
   localparam logic [1:0] FUNC_SINE = 2'd1;
   localparam logic [1:0] FUNC_BOTH = 2'd2;

   // constants in internal q.30, Q60_ONE in q.60
   localparam logic signed [63:0] Q_ONE     = 64'sd1073741824;
   localparam logic signed [63:0] Q_HALF_PI = 64'sd1686629713;
   localparam logic signed [63:0] Q_PI      = 64'sd3373259426;
   localparam logic signed [63:0] Q_TWO_PI  = 64'sd6746518852;
   localparam logic signed [63:0] Q_CROSS   = 64'sd701577539;
   localparam logic signed [63:0] Q_M_HALF  = -64'sd536870912;
   localparam logic signed [63:0] Q_C24     = 64'sd44739243;
   localparam logic signed [63:0] Q_C6      = 64'sd178956971;
   localparam logic signed [63:0] Q_C120    = 64'sd8947849;
   localparam logic [63:0]        Q60_ONE   = 64'd1 << 60;

   // folded angle handed from the fold stages to the polynomial stages
   typedef struct packed {
      logic signed [31:0] x;      // a near zero, a - pi/2 otherwise
      logic               near0;
      logic               neg;
      logic [1:0]         func;
      logic               pos;    // sine sign for the combined mode
   } fold_out_type;

   // polynomial result with its sideband
   typedef struct packed {
      logic signed [31:0] c;
      logic [1:0]         func;
      logic               pos;
   } poly_out_type;

   // sideband that travels through the square root stages
   typedef struct packed {
      logic signed [31:0] first;
      logic [1:0]         func;
      logic               pos;
   } root_side_type;

   // q.30 product rounding: sign-magnitude, nearest, ties away from zero
   function automatic logic signed [63:0] qround(input logic signed [63:0] p);
      logic [63:0] m;
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << (WF - 1))) >> WF;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

   // q.30 to output format with rounding on narrowing and 32-bit saturation
   function automatic logic signed [31:0] to_out(input logic signed [63:0] r,
                                                 input int sh);
      logic signed [95:0] w;
      logic [63:0]        m;
      logic [63:0]        half;
      m    = r[63] ? 64'(-r) : 64'(r);
      half = '0;
      if (sh >= 0) begin
         w = $signed({{32{r[63]}}, r}) <<< sh;
      end else begin
         half = 64'd1 << (-sh - 1);
         m    = (m + half) >> (-sh);
         w    = r[63] ? -$signed({32'd0, m}) : $signed({32'd0, m});
      end
      if (w > 96'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (w < -96'sd2147483648) begin
         return 32'sh80000000;
      end
      return w[31:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fcs_fold.sv
// fast cosine/sine unit: four-stage angle conversion and range folding
// depends on fcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcs_fold #(
   parameter int ANGLE_FRAC_BITS = fcs_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [1:0]           in_func,
   input  wire logic signed [31:0]   in_angle,
   output logic                      out_valid,
   output fcs_pkg::fold_out_type     out_data
);

   localparam int SHL = (fcs_pkg::WF > ANGLE_FRAC_BITS) ? fcs_pkg::WF - ANGLE_FRAC_BITS : 0;
   localparam int SHR = (ANGLE_FRAC_BITS > fcs_pkg::WF) ? ANGLE_FRAC_BITS - fcs_pkg::WF : 0;
   localparam int VW  = 33 + SHL;

   logic signed [VW-1:0] v_in;
   logic signed [VW-1:0] vs_in;
   logic [VW-1:0]        mag_in;
   logic                 pos_in;
   logic [VW-1:0]        mag_ff;
   logic [63:0]          t2;
   logic [32:0]          a2_in;
   logic [32:0]          a2_ff;
   logic [31:0]          a3_in;
   logic [31:0]          a3_ff;
   logic [31:0]          a4;
   logic                 neg4;
   fcs_pkg::fold_out_type fo_in;
   fcs_pkg::fold_out_type fo_ff;
   logic [1:0]           func1_ff, func2_ff, func3_ff;
   logic                 pos1_ff, pos2_ff, pos3_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: convert to q.30, shift by pi/2 for sine, take magnitude
   always_comb begin
      v_in   = (VW'(in_angle) <<< SHL) >>> SHR;
      vs_in  = (in_func == fcs_pkg::FUNC_SINE) ? v_in + VW'(fcs_pkg::Q_HALF_PI) : v_in;
      mag_in = vs_in[VW-1] ? VW'(-vs_in) : VW'(vs_in);
      if (64'(v_in) > fcs_pkg::Q_PI) begin
         pos_in = 1'b0;
      end else begin
         pos_in = (v_in > 0) || (64'(v_in) < -fcs_pkg::Q_PI);
      end
   end

   // stage 2: one 2pi subtraction, then clamp to 2pi
   always_comb begin
      t2 = 64'(mag_ff);
      if (t2 > 64'(fcs_pkg::Q_TWO_PI)) begin
         t2 = t2 - 64'(fcs_pkg::Q_TWO_PI);
      end
      if (t2 > 64'(fcs_pkg::Q_TWO_PI)) begin
         t2 = 64'(fcs_pkg::Q_TWO_PI);
      end
      a2_in = t2[32:0];
   end

   // stage 3: mirror about pi
   always_comb begin
      if (34'(a2_ff) > 34'(fcs_pkg::Q_PI)) begin
         a3_in = 32'(34'(fcs_pkg::Q_TWO_PI) - 34'(a2_ff));
      end else begin
         a3_in = a2_ff[31:0];
      end
   end

   // stage 4: mirror about pi/2, pick the expansion point
   always_comb begin
      if (33'(a3_ff) > 33'(fcs_pkg::Q_HALF_PI)) begin
         a4   = 32'(33'(fcs_pkg::Q_PI) - 33'(a3_ff));
         neg4 = 1'b1;
      end else begin
         a4   = a3_ff;
         neg4 = 1'b0;
      end
      fo_in.near0 = 33'(a4) < 33'(fcs_pkg::Q_CROSS);
      fo_in.x     = fo_in.near0 ? $signed(a4) : $signed(a4 - 32'(fcs_pkg::Q_HALF_PI));
      fo_in.neg   = neg4;
      fo_in.func  = func3_ff;
      fo_in.pos   = pos3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         func1_ff <= in_func;
         pos1_ff  <= pos_in;
         a2_ff    <= a2_in;
         func2_ff <= func1_ff;
         pos2_ff  <= pos1_ff;
         a3_ff    <= a3_in;
         func3_ff <= func2_ff;
         pos3_ff  <= pos2_ff;
         fo_ff    <= fo_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = fo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fcs_poly.sv
// fast cosine/sine unit: five-stage taylor evaluation about zero or pi/2
// depends on fcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcs_poly (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire fcs_pkg::fold_out_type in_data,
   output logic                       out_valid,
   output fcs_pkg::poly_out_type      out_data
);

   logic signed [63:0] p1, p2, p3, p5;
   logic signed [63:0] q1, q2, q3, q5;
   logic signed [31:0] sq_in, t_in, w_in, y_in, r5;
   logic signed [31:0] u3;
   logic signed [63:0] k2;
   fcs_pkg::fold_out_type f1_ff, f2_ff, f3_ff, f4_ff;
   logic signed [31:0] sq1_ff, sq2_ff;
   logic signed [31:0] t2_ff, w3_ff, y4_ff;
   fcs_pkg::poly_out_type po_in, po_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   always_comb begin
      // square of the reduced angle
      p1    = 64'(in_data.x) * 64'(in_data.x);
      q1    = fcs_pkg::qround(p1);
      sq_in = q1[31:0];
      // first coefficient product
      k2    = f1_ff.near0 ? fcs_pkg::Q_C24 : fcs_pkg::Q_C120;
      p2    = 64'(sq1_ff) * k2;
      q2    = fcs_pkg::qround(p2);
      t_in  = q2[31:0];
      // inner term times the square
      u3    = f2_ff.near0 ? 32'(fcs_pkg::Q_M_HALF) + t2_ff : 32'(fcs_pkg::Q_C6) - t2_ff;
      p3    = 64'(sq2_ff) * 64'(u3);
      q3    = fcs_pkg::qround(p3);
      w_in  = q3[31:0];
      // constant term
      y_in  = f3_ff.near0 ? 32'(fcs_pkg::Q_ONE) + w3_ff : w3_ff - 32'(fcs_pkg::Q_ONE);
      // odd series about pi/2 takes one more factor of d
      p5    = 64'(f4_ff.x) * 64'(y4_ff);
      q5    = fcs_pkg::qround(p5);
      r5    = f4_ff.near0 ? y4_ff : q5[31:0];
      po_in.c    = f4_ff.neg ? -r5 : r5;
      po_in.func = f4_ff.func;
      po_in.pos  = f4_ff.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff  <= in_data;
         sq1_ff <= sq_in;
         f2_ff  <= f1_ff;
         sq2_ff <= sq1_ff;
         t2_ff  <= t_in;
         f3_ff  <= f2_ff;
         w3_ff  <= w_in;
         f4_ff  <= f3_ff;
         y4_ff  <= y_in;
         po_ff  <= po_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = po_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fcs_isqrt.sv
// fast cosine/sine unit: pipelined rounded square root of 1 - c^2,
// two result bits per stage; depends on fcs_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcs_isqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [63:0]            in_c2,
   input  wire fcs_pkg::root_side_type in_side,
   output logic                        out_valid,
   output logic [31:0]                 out_root,
   output fcs_pkg::root_side_type      out_side
);

   localparam int PER    = 2;
   localparam int STAGES = 32 / PER;
   localparam int RW     = 35;

   logic [63:0]            diff_in;
   logic [63:0]            rad_ff  [STAGES];
   logic [RW-1:0]          rem_ff  [STAGES+1];
   logic [31:0]            root_ff [STAGES+1];
   fcs_pkg::root_side_type side_ff [STAGES+1];
   logic                   vld_ff  [STAGES+1];

   assign diff_in = (in_c2 >= fcs_pkg::Q60_ONE) ? 64'd0 : fcs_pkg::Q60_ONE - in_c2;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= diff_in;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [63:0]   rad_c;
      logic [RW-1:0] rem_c;
      logic [31:0]   root_c;
      logic [RW-1:0] trial;

      // restoring digit recurrence, one radicand bit pair per step
      always_comb begin
         rad_c  = rad_ff[k];
         rem_c  = rem_ff[k];
         root_c = root_ff[k];
         trial  = '0;
         for (int i = 0; i < PER; i++) begin
            rem_c = {rem_c[RW-3:0], rad_c[63:62]};
            rad_c = {rad_c[61:0], 2'b00};
            trial = RW'({root_c, 2'b01});
            if (rem_c >= trial) begin
               rem_c  = rem_c - trial;
               root_c = {root_c[30:0], 1'b1};
            end else begin
               root_c = {root_c[30:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_c;
            root_ff[k+1] <= root_c;
            side_ff[k+1] <= side_ff[k];
         end
      end

      if (k + 1 < STAGES) begin : g_rad
         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[k+1] <= rad_c;
            end
         end
      end
   end

   // round to nearest: bump when the remainder exceeds the root
   assign out_root  = root_ff[STAGES] + 32'(rem_ff[STAGES] > RW'(root_ff[STAGES]));
   assign out_side  = side_ff[STAGES];
   assign out_valid = vld_ff[STAGES];

endmodule

`default_nettype wire

FILE: hw/rtl/fast_cosine_sine_unit.sv
// fast cosine/sine unit, top level: fold, polynomial, square root, output skid
// an accepted request word reaches its response word through the registered stages below;
// throughput one word per cycle while the skid is empty, set by the fully pipelined datapath
// (4 fold stages, 5 polynomial stages, 1 square stage, 17 root stages, 1 output)
// reset is synchronous, active high, and clears all valid bits; no warm-up pass
// depends on fcs_pkg, fcs_fold, fcs_poly, fcs_isqrt
`timescale 1ns / 1ps
`default_nettype none

module fast_cosine_sine_unit #(
   parameter int ANGLE_FRAC_BITS  = fcs_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int RESULT_FRAC_BITS = fcs_pkg::RESULT_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_angle,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_first_value,
   output logic signed [31:0]      rsp_second_value
);

   localparam int OUT_SH = RESULT_FRAC_BITS - fcs_pkg::WF;

   // whole pipeline advances together; it freezes only while the skid holds a word
   logic                   en;
   logic                   fold_valid;
   fcs_pkg::fold_out_type  fold_data;
   logic                   poly_valid;
   fcs_pkg::poly_out_type  poly_data;
   // square stage: cosine result formatted, c^2 for the combined mode
   logic                   sqv_ff;
   logic [63:0]            c2_in, c2_ff;
   fcs_pkg::root_side_type side_in, side_ff;
   // root output
   logic                   fin_valid;
   logic [31:0]            fin_root;
   fcs_pkg::root_side_type fin_side;
   logic signed [31:0]     fin_sine;
   logic signed [31:0]     fin_second;
   logic                   fin_fire;
   // output register and skid
   logic                   out_free;
   logic                   out_v_ff, skid_v_ff;
   logic signed [31:0]     out_first_ff, out_second_ff;
   logic signed [31:0]     skid_first_ff, skid_second_ff;

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   fcs_fold #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_func   (req_func),
      .in_angle  (req_angle),
      .out_valid (fold_valid),
      .out_data  (fold_data)
   );

   fcs_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fold_valid),
      .in_data   (fold_data),
      .out_valid (poly_valid),
      .out_data  (poly_data)
   );

   // square stage: format the cosine (or sine) word and square the cosine
   always_comb begin
      c2_in         = 64'(64'(poly_data.c) * 64'(poly_data.c));
      side_in.first = fcs_pkg::to_out(64'(poly_data.c), OUT_SH);
      side_in.func  = poly_data.func;
      side_in.pos   = poly_data.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff <= 1'b0;
      end else if (en) begin
         sqv_ff <= poly_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff   <= c2_in;
         side_ff <= side_in;
      end
   end

   fcs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqv_ff),
      .in_c2     (c2_ff),
      .in_side   (side_ff),
      .out_valid (fin_valid),
      .out_root  (fin_root),
      .out_side  (fin_side)
   );

   // sign from the unfolded angle, second word only in the combined mode
   always_comb begin
      fin_sine   = fin_side.pos ? $signed(fin_root) : -$signed(fin_root);
      fin_second = (fin_side.func == fcs_pkg::FUNC_BOTH) ?
                   fcs_pkg::to_out(64'(fin_sine), OUT_SH) : 32'sd0;
   end

   assign fin_fire = fin_valid && en;
   assign out_free = !out_v_ff || !rsp_stall;

   // output register plus one skid entry: a word stalled at the output parks the
   // next finished word in the skid, and only then is the request side stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= fin_fire;
         end
      end else if (fin_fire) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_v_ff) begin
            out_first_ff  <= skid_first_ff;
            out_second_ff <= skid_second_ff;
         end else if (fin_fire) begin
            out_first_ff  <= fin_side.first;
            out_second_ff <= fin_second;
         end
      end else if (fin_fire) begin
         skid_first_ff  <= fin_side.first;
         skid_second_ff <= fin_second;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_first_value  = out_first_ff;
   assign rsp_second_value = out_second_ff;

   // skid holds a word only behind a valid output word
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid full while output register empty");

   // skid fills only after a stalled output word
   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   // a frozen pipeline keeps its finished word
   a_frozen_keeps : assert property (@(posedge clock) disable iff (reset)
      fin_valid && !en |=> fin_valid)
      else $error("finished word lost while pipeline frozen");

endmodule

`default_nettype wire
